### rtl/core/crcfr_pkg.sv
// Package with types, codes and the CRC-8 step for the frame receiver.
package crcfr_pkg;

  localparam logic [7:0]  SYNC_BYTE        = 8'hFA;
  localparam logic [7:0]  END_BYTE         = 8'hFE;
  localparam logic [7:0]  CRC_POLY         = 8'h07;
  localparam logic [15:0] MAX_PAYLOAD_RST  = 16'd1024;

  typedef enum logic [2:0] {
    KIND_DATA     = 3'd0,
    KIND_GOOD     = 3'd1,
    KIND_HDR_BAD  = 3'd2,
    KIND_DATA_BAD = 3'd3,
    KIND_BAD_END  = 3'd4,
    KIND_TOO_LONG = 3'd5
  } kind_e;

  typedef enum logic [7:0] {
    ST_HUNT     = 8'b0000_0001,
    ST_LEN_LO   = 8'b0000_0010,
    ST_LEN_HI   = 8'b0000_0100,
    ST_HDR_CRC  = 8'b0000_1000,
    ST_SYNC2    = 8'b0001_0000,
    ST_PAYLOAD  = 8'b0010_0000,
    ST_DATA_CRC = 8'b0100_0000,
    ST_END      = 8'b1000_0000
  } state_e;

  typedef struct packed {
    logic       valid;
    logic [7:0] rx_byte;
  } in_item_t;

  function automatic logic [7:0] crc8_update(logic [7:0] crc, logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (v[7]) begin
        v = {v[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

### rtl/core/crcfr_in_reg.sv
// Input register stage for received bytes.
module crcfr_in_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         in_byte_i,
  input  logic               consume_i,
  output crcfr_pkg::in_item_t item_o
);
  import crcfr_pkg::*;

  logic       valid_q, valid_d;
  logic [7:0] byte_q;

  assign in_ready_o = !valid_q || consume_i;
  assign valid_d    = (in_valid_i && in_ready_o) || (valid_q && !consume_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= in_byte_i;
    end
  end

  assign item_o.valid   = valid_q;
  assign item_o.rx_byte = byte_q;

endmodule

### rtl/core/crcfr_deframer.sv
// Frame state machine, CRC checks and result register.
module crcfr_deframer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_wdata_i,
  input  crcfr_pkg::in_item_t item_i,
  output logic                consume_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [2:0]          out_kind_o,
  output logic [7:0]          out_data_o,
  output logic [15:0]         out_len_o
);
  import crcfr_pkg::*;

  state_e      state_q, state_d;
  logic [15:0] max_q;
  logic [15:0] len_q, len_d;
  logic [15:0] cnt_q, cnt_d;
  logic [7:0]  hcrc_q, hcrc_d;
  logic [7:0]  hrx_q, hrx_d;
  logic [7:0]  dcrc_q, dcrc_d;
  logic [7:0]  drx_q, drx_d;
  logic        emit;
  kind_e       kind;
  logic [7:0]  data;
  logic [7:0]  b;
  logic [15:0] cnt_inc;

  logic        ovalid_q, ovalid_d;
  kind_e       okind_q;
  logic [7:0]  odata_q;
  logic [15:0] olen_q;

  assign b         = item_i.rx_byte;
  assign consume_o = item_i.valid && (!ovalid_q || out_ready_i);
  assign cnt_inc   = cnt_q + 16'd1;

  always_comb begin
    state_d = state_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    hcrc_d  = hcrc_q;
    hrx_d   = hrx_q;
    dcrc_d  = dcrc_q;
    drx_d   = drx_q;
    emit    = 1'b0;
    kind    = KIND_DATA;
    data    = 8'd0;
    case (state_q)
      ST_HUNT: begin
        if (b == SYNC_BYTE) begin
          hcrc_d  = crc8_update(8'd0, b);
          dcrc_d  = 8'd0;
          cnt_d   = 16'd0;
          len_d   = 16'd0;
          state_d = ST_LEN_LO;
        end
      end
      ST_LEN_LO: begin
        len_d   = {8'd0, b};
        hcrc_d  = crc8_update(hcrc_q, b);
        state_d = ST_LEN_HI;
      end
      ST_LEN_HI: begin
        len_d  = {b, len_q[7:0]};
        hcrc_d = crc8_update(hcrc_q, b);
        if (len_d > max_q) begin
          emit    = 1'b1;
          kind    = KIND_TOO_LONG;
          state_d = ST_HUNT;
        end else begin
          state_d = ST_HDR_CRC;
        end
      end
      ST_HDR_CRC: begin
        hrx_d   = b;
        state_d = ST_SYNC2;
      end
      ST_SYNC2: begin
        state_d = (len_q == 16'd0) ? ST_DATA_CRC : ST_PAYLOAD;
      end
      ST_PAYLOAD: begin
        dcrc_d = crc8_update(dcrc_q, b);
        cnt_d  = cnt_inc;
        if (cnt_inc >= len_q) begin
          state_d = ST_DATA_CRC;
        end
        emit = 1'b1;
        kind = KIND_DATA;
        data = b;
      end
      ST_DATA_CRC: begin
        drx_d   = b;
        state_d = ST_END;
      end
      ST_END: begin
        emit = 1'b1;
        if (b != END_BYTE) begin
          kind = KIND_BAD_END;
        end else if (hcrc_q != hrx_q) begin
          kind = KIND_HDR_BAD;
        end else if (dcrc_q != drx_q) begin
          kind = KIND_DATA_BAD;
        end else begin
          kind = KIND_GOOD;
        end
        state_d = ST_HUNT;
      end
      default: begin
        state_d = ST_HUNT;
      end
    endcase
  end

  assign ovalid_d = (consume_o && emit) || (ovalid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_HUNT;
      max_q    <= MAX_PAYLOAD_RST;
      len_q    <= 16'd0;
      cnt_q    <= 16'd0;
      hcrc_q   <= 8'd0;
      hrx_q    <= 8'd0;
      dcrc_q   <= 8'd0;
      drx_q    <= 8'd0;
      ovalid_q <= 1'b0;
    end else begin
      ovalid_q <= ovalid_d;
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
      if (consume_o) begin
        state_q <= state_d;
        len_q   <= len_d;
        cnt_q   <= cnt_d;
        hcrc_q  <= hcrc_d;
        hrx_q   <= hrx_d;
        dcrc_q  <= dcrc_d;
        drx_q   <= drx_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (consume_o && emit) begin
      okind_q <= kind;
      odata_q <= data;
      olen_q  <= len_d;
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_kind_o  = okind_q;
  assign out_data_o  = odata_q;
  assign out_len_o   = olen_q;

endmodule

### rtl/core/crc8_frame_receiver.sv
// Top level of the sync/length/CRC-8 frame receiver.
//
//  channel  | dir | handshake            | contents
//  ---------+-----+----------------------+------------------------------------
//  s_axis   | in  | tvalid/tready        | tdata[7:0] rx_byte
//  m_axis   | out | tvalid/tready        | tuser kind, tdata data_byte, length
//  cfg      | in  | cfg_we_i             | cfg_wdata_i max_payload
//
//  One byte per cycle sustained while the result is not stalled; a byte is held in
//  the input register and is processed into the result register when consumed.
//  The CRC-8 step for one byte is combinational XOR logic.
//  Reset clears the frame state, sets max_payload to 1024, empties both stages.
//  A stalled result holds; input keeps flowing while either stage has room.
module crc8_frame_receiver (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] data_byte, [23:8] frame_length
  output logic [2:0]  m_axis_tuser,   // [2:0] kind
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);
  import crcfr_pkg::*;

  in_item_t    item;
  logic        consume;
  logic [7:0]  out_data;
  logic [15:0] out_len;

  crcfr_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_byte_i  (s_axis_tdata),
    .consume_i  (consume),
    .item_o     (item)
  );

  crcfr_deframer u_deframer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (item),
    .consume_o   (consume),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_kind_o  (m_axis_tuser),
    .out_data_o  (out_data),
    .out_len_o   (out_len)
  );

  assign m_axis_tdata = {out_len, out_data};

endmodule

### rtl/core/crcfr_checker.sv
// Port-level checker for the frame receiver and its bind.
module crcfr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);
  import crcfr_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result changed");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser <= KIND_TOO_LONG)
    else $error("result kind out of range");

  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != KIND_DATA |-> m_axis_tdata[7:0] == 8'd0)
    else $error("status result carries data byte");

  a_no_spont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tvalid && s_axis_tready) ##1 (!m_axis_tvalid && !(s_axis_tvalid && s_axis_tready))
      |=> !m_axis_tvalid)
    else $error("result without input");

  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

endmodule

bind crc8_frame_receiver crcfr_checker u_crcfr_checker (.*);
